// File: design/baled_pkg.sv
// Shared types, codes and constants of the button-adjusted LED blinker.
package baled_pkg;

   localparam int PERIOD_WIDTH        = 16;
   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int SCALE_SHIFT         = 10;
   localparam int REQ_DATA_WIDTH      = 8;
   localparam int RSP_DATA_WIDTH      = 24;

   // Period scale factors in 1/1024 units: about 1.2 and 0.8
   localparam logic [10:0] MUL_UP   = 11'd1229;
   localparam logic [9:0]  MUL_DOWN = 10'd819;

   localparam logic [PERIOD_WIDTH-1:0] START_PERIOD_RESET    = 16'd500;
   localparam logic [PERIOD_WIDTH-1:0] REPEAT_INTERVAL_RESET = 16'd250;
   localparam logic [PERIOD_WIDTH-1:0] MIN_PERIOD_RESET      = 16'd2;
   localparam logic [PERIOD_WIDTH-1:0] MAX_PERIOD_RESET      = 16'd65535;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_UP    = 2'd1,
      REQ_RESET = 2'd2,
      REQ_DOWN  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_START_PERIOD    = 2'd0,
      CSR_REPEAT_INTERVAL = 2'd1,
      CSR_MIN_PERIOD      = 2'd2,
      CSR_MAX_PERIOD      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PERIOD_WIDTH-1:0] start_period;
      logic [PERIOD_WIDTH-1:0] repeat_interval;
      logic [PERIOD_WIDTH-1:0] min_period;
      logic [PERIOD_WIDTH-1:0] max_period;
   } csr_type;

   typedef struct packed {
      req_kind_type kind;
      logic         up_held;
      logic         down_held;
   } req_item_type;

   typedef struct packed {
      logic                    led_on;
      logic                    led_changed;
      logic [PERIOD_WIDTH-1:0] current_period;
   } rsp_item_type;

   typedef struct packed {
      logic led;
      logic up_active;
      logic down_active;
   } flags_type;

endpackage

// File: design/baled_step.sv
// Next-state logic of the blinker: blink countdown, repeat countdowns, period scaling and reset to the start period.
module baled_step #(
   parameter int COUNT_WIDTH = baled_pkg::COUNT_WIDTH_DEFAULT
) (
   input  baled_pkg::csr_type                      csr,
   input  baled_pkg::req_item_type                 item,
   input  logic [baled_pkg::PERIOD_WIDTH-1:0]      period_cur,
   input  baled_pkg::flags_type                    flags_cur,
   input  logic [COUNT_WIDTH-1:0]                  blink_cur,
   input  logic [COUNT_WIDTH-1:0]                  up_cnt_cur,
   input  logic [COUNT_WIDTH-1:0]                  down_cnt_cur,
   output logic [baled_pkg::PERIOD_WIDTH-1:0]      period_nxt,
   output baled_pkg::flags_type                    flags_nxt,
   output logic [COUNT_WIDTH-1:0]                  blink_nxt,
   output logic [COUNT_WIDTH-1:0]                  up_cnt_nxt,
   output logic [COUNT_WIDTH-1:0]                  down_cnt_nxt,
   output logic                                    changed
);
   import baled_pkg::*;

   localparam int UP_PROD_W   = PERIOD_WIDTH + $bits(MUL_UP);
   localparam int DOWN_PROD_W = PERIOD_WIDTH + $bits(MUL_DOWN);
   localparam int WIDE_W      = COUNT_WIDTH + PERIOD_WIDTH;

   function automatic logic [PERIOD_WIDTH-1:0] scale_up(
      input logic [PERIOD_WIDTH-1:0] p,
      input logic [PERIOD_WIDTH-1:0] ceiling
   );
      logic [UP_PROD_W-1:0]              prod;
      logic [UP_PROD_W-SCALE_SHIFT-1:0]  q;
      prod = UP_PROD_W'(p) * UP_PROD_W'(MUL_UP);
      q    = prod[UP_PROD_W-1:SCALE_SHIFT];
      scale_up = (q > (UP_PROD_W-SCALE_SHIFT)'(ceiling)) ? ceiling : q[PERIOD_WIDTH-1:0];
   endfunction

   function automatic logic [PERIOD_WIDTH-1:0] scale_down(
      input logic [PERIOD_WIDTH-1:0] p,
      input logic [PERIOD_WIDTH-1:0] floor_val
   );
      logic [DOWN_PROD_W-1:0]             prod;
      logic [DOWN_PROD_W-SCALE_SHIFT-1:0] q;
      prod = DOWN_PROD_W'(p) * DOWN_PROD_W'(MUL_DOWN);
      q    = prod[DOWN_PROD_W-1:SCALE_SHIFT];
      scale_down = (q < (DOWN_PROD_W-SCALE_SHIFT)'(floor_val)) ? floor_val
                                                               : q[PERIOD_WIDTH-1:0];
   endfunction

   logic [WIDE_W-1:0]         half_wide;
   logic [WIDE_W-1:0]         rep_wide;
   logic [COUNT_WIDTH-1:0]    half_fit;
   logic [COUNT_WIDTH-1:0]    rep_fit;
   logic                      is_tick;
   logic                      blink_exp;
   logic                      up_exp;
   logic                      down_exp;
   logic                      up_fire;
   logic                      down_fire;
   logic [PERIOD_WIDTH-1:0]   period_up;
   logic [PERIOD_WIDTH-1:0]   period_after_up;
   logic [PERIOD_WIDTH-1:0]   period_down;

   // Reloads truncate or zero-extend to the counter width
   assign half_wide = {{COUNT_WIDTH{1'b0}}, 1'b0, period_cur[PERIOD_WIDTH-1:1]};
   assign rep_wide  = {{COUNT_WIDTH{1'b0}}, csr.repeat_interval};
   assign half_fit  = half_wide[COUNT_WIDTH-1:0];
   assign rep_fit   = rep_wide[COUNT_WIDTH-1:0];

   assign is_tick   = (item.kind == REQ_TICK);
   assign blink_exp = (blink_cur <= COUNT_WIDTH'(1));
   assign up_exp    = (up_cnt_cur <= COUNT_WIDTH'(1));
   assign down_exp  = (down_cnt_cur <= COUNT_WIDTH'(1));
   assign up_fire   = is_tick && flags_cur.up_active && up_exp && item.up_held;
   assign down_fire = is_tick && flags_cur.down_active && down_exp && item.down_held;

   // Up step comes before down step within one tick
   assign period_up       = scale_up(period_cur, csr.max_period);
   assign period_after_up = up_fire ? period_up : period_cur;
   assign period_down     = scale_down(period_after_up, csr.min_period);

   always_comb begin
      period_nxt   = period_cur;
      flags_nxt    = flags_cur;
      blink_nxt    = blink_cur;
      up_cnt_nxt   = up_cnt_cur;
      down_cnt_nxt = down_cnt_cur;
      changed      = 1'b0;
      unique case (item.kind)
         REQ_TICK: begin
            if (blink_exp) begin
               flags_nxt.led = ~flags_cur.led;
               changed       = 1'b1;
               blink_nxt     = half_fit;
            end else begin
               blink_nxt = blink_cur - COUNT_WIDTH'(1);
            end
            if (flags_cur.up_active) begin
               if (!up_exp) begin
                  up_cnt_nxt = up_cnt_cur - COUNT_WIDTH'(1);
               end else if (item.up_held) begin
                  up_cnt_nxt = rep_fit;
               end else begin
                  flags_nxt.up_active = 1'b0;
               end
            end
            if (flags_cur.down_active) begin
               if (!down_exp) begin
                  down_cnt_nxt = down_cnt_cur - COUNT_WIDTH'(1);
               end else if (item.down_held) begin
                  down_cnt_nxt = rep_fit;
               end else begin
                  flags_nxt.down_active = 1'b0;
               end
            end
            period_nxt = down_fire ? period_down : period_after_up;
         end
         REQ_UP: begin
            up_cnt_nxt          = rep_fit;
            flags_nxt.up_active = 1'b1;
            period_nxt          = period_up;
         end
         REQ_RESET: begin
            period_nxt = csr.start_period;
         end
         REQ_DOWN: begin
            down_cnt_nxt          = rep_fit;
            flags_nxt.down_active = 1'b1;
            period_nxt            = period_down;
         end
         default: begin
            period_nxt = period_cur;
         end
      endcase
   end

endmodule

// File: design/button_adjusted_led_blinker_unit.sv
// Top level of the button-adjusted LED blinker: handshakes, registers and state.
//
// Each request (a tick or a button edge) yields exactly one response carrying the LED
// level, a toggle flag and the blink period after that request. The unit takes one
// request per clock while responses are not stalled: a request waits in the input
// register, the next-state step (countdowns and the two constant-coefficient period
// scalings) runs on it there, and the response is loaded into the output register
// when the step advances.
// A stalled response holds the input register;
// the unit keeps accepting as long as either register can move. Registers are written
// through the csr port, which is always ready; write them only while the unit is idle.
module button_adjusted_led_blinker_unit #(
   parameter int COUNT_WIDTH = baled_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [baled_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,   // up_held, down_held
   input  logic [1:0]                             req_tuser,   // req_type
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [baled_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,   // led_on, led_changed,
                                                               // current_period
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [1:0]                             csr_index,
   input  logic [baled_pkg::PERIOD_WIDTH-1:0]     csr_data
);
   import baled_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] BLINK_RESET = COUNT_WIDTH'(START_PERIOD_RESET >> 1);
   localparam int RSP_PAD = RSP_DATA_WIDTH - $bits(rsp_item_type);

   csr_type                   csr_ff;
   csr_type                   csr_in;
   logic                      in_valid_ff;
   logic                      in_valid_in;
   req_item_type              in_item_ff;
   req_item_type              req_item;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   rsp_item_type              rsp_item_ff;
   rsp_item_type              rsp_item_in;
   logic [PERIOD_WIDTH-1:0]   period_ff;
   logic [PERIOD_WIDTH-1:0]   period_in;
   flags_type                 flags_ff;
   flags_type                 flags_in;
   logic [COUNT_WIDTH-1:0]    blink_ff;
   logic [COUNT_WIDTH-1:0]    blink_in;
   logic [COUNT_WIDTH-1:0]    up_cnt_ff;
   logic [COUNT_WIDTH-1:0]    up_cnt_in;
   logic [COUNT_WIDTH-1:0]    down_cnt_ff;
   logic [COUNT_WIDTH-1:0]    down_cnt_in;
   logic                      changed;
   logic                      advance;
   logic                      step_go;

   assign req_item.kind      = req_kind_type'(req_tuser);
   assign req_item.up_held   = req_tdata[0];
   assign req_item.down_held = req_tdata[1];

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step_go    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   baled_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .csr          (csr_ff),
      .item         (in_item_ff),
      .period_cur   (period_ff),
      .flags_cur    (flags_ff),
      .blink_cur    (blink_ff),
      .up_cnt_cur   (up_cnt_ff),
      .down_cnt_cur (down_cnt_ff),
      .period_nxt   (period_in),
      .flags_nxt    (flags_in),
      .blink_nxt    (blink_in),
      .up_cnt_nxt   (up_cnt_in),
      .down_cnt_nxt (down_cnt_in),
      .changed      (changed)
   );

   assign rsp_item_in.led_on         = flags_in.led;
   assign rsp_item_in.led_changed    = changed;
   assign rsp_item_in.current_period = period_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_PERIOD:    csr_in.start_period    = csr_data;
            CSR_REPEAT_INTERVAL: csr_in.repeat_interval = csr_data;
            CSR_MIN_PERIOD:      csr_in.min_period      = csr_data;
            CSR_MAX_PERIOD:      csr_in.max_period      = csr_data;
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.start_period    <= START_PERIOD_RESET;
         csr_ff.repeat_interval <= REPEAT_INTERVAL_RESET;
         csr_ff.min_period      <= MIN_PERIOD_RESET;
         csr_ff.max_period      <= MAX_PERIOD_RESET;
         in_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         period_ff              <= START_PERIOD_RESET;
         flags_ff               <= '0;
         blink_ff               <= BLINK_RESET;
         up_cnt_ff              <= '0;
         down_cnt_ff            <= '0;
      end else begin
         csr_ff       <= csr_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_go) begin
            period_ff   <= period_in;
            flags_ff    <= flags_in;
            blink_ff    <= blink_in;
            up_cnt_ff   <= up_cnt_in;
            down_cnt_ff <= down_cnt_in;
         end
      end
   end

   // Payload registers: hold while stalled
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item;
      end
      if (step_go) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_item_ff.current_period,
                        rsp_item_ff.led_changed, rsp_item_ff.led_on};

   // The reported toggle flag matches the actual LED change
   a_led_toggle: assert property (@(posedge clock) disable iff (reset)
      step_go |=> (flags_ff.led == ($past(flags_ff.led) ^ rsp_item_ff.led_changed)))
      else $error("LED level disagrees with toggle flag");

   // Button edges and reset edges leave the blink countdown and LED alone
   a_edge_no_blink: assert property (@(posedge clock) disable iff (reset)
      (step_go && in_item_ff.kind != REQ_TICK) |=> ($stable(blink_ff) && $stable(flags_ff.led)))
      else $error("blink state moved on a button edge");

   // An up edge arms the up repeat
   a_up_arms: assert property (@(posedge clock) disable iff (reset)
      (step_go && in_item_ff.kind == REQ_UP) |=> flags_ff.up_active)
      else $error("up edge did not arm repeat");

   // The response register shows the period state it was loaded with
   a_rsp_period: assert property (@(posedge clock) disable iff (reset)
      step_go |=> (rsp_item_ff.current_period == period_ff))
      else $error("response period differs from period state");

endmodule

// File: sim/button_adjusted_led_blinker_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the button-adjusted LED blinker unit.
module button_adjusted_led_blinker_unit_tb;
   import baled_pkg::*;

   localparam int          CNT_W        = COUNT_WIDTH_DEFAULT;
   localparam logic [31:0] GAIN_UP      = 32'd1229;
   localparam logic [31:0] GAIN_DOWN    = 32'd819;
   localparam int          GAIN_SHIFT   = 10;
   localparam int          DRAIN_CYCLES = 4;
   localparam int          LONG_HOLD    = 100;
   localparam int          PHASES       = 8;
   localparam int          PHASE_ITEMS  = 241;

   typedef struct packed {
      logic                    is_csr;
      csr_index_type           idx;
      logic [PERIOD_WIDTH-1:0] value;
      req_kind_type            kind;
      logic                    up;
      logic                    down;
      logic                    typed;
      logic [PERIOD_WIDTH-1:0] period;
   } stim_row_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic [1:0]                req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [1:0]                csr_index  = '0;
   logic [PERIOD_WIDTH-1:0]   csr_data   = '0;

   // shadow registers and blinker state
   logic [PERIOD_WIDTH-1:0] cfg_start, cfg_repeat, cfg_min, cfg_max;
   logic [PERIOD_WIDTH-1:0] cur_period;
   logic [CNT_W-1:0]        toggle_cnt, up_rpt_cnt, dn_rpt_cnt;
   logic                    led_q, up_rpt_on, dn_rpt_on;

   rsp_item_type led_period_q[$];
   stim_row_type directed_rows[$];
   int           mismatch_count = 0;
   bit           send_idle_on   = 1'b0;
   bit           rsp_idle_on    = 1'b1;
   bit           hold_rsp_req   = 1'b0;

   button_adjusted_led_blinker_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [PERIOD_WIDTH-1:0] scale_period_up(logic [PERIOD_WIDTH-1:0] p);
      logic [31:0] prod;
      prod = ({16'd0, p} * GAIN_UP) >> GAIN_SHIFT;
      if (prod > {16'd0, cfg_max})
         prod = {16'd0, cfg_max};
      return prod[PERIOD_WIDTH-1:0];
   endfunction

   function automatic logic [PERIOD_WIDTH-1:0] scale_period_down(logic [PERIOD_WIDTH-1:0] p);
      logic [31:0] prod;
      prod = ({16'd0, p} * GAIN_DOWN) >> GAIN_SHIFT;
      if (prod < {16'd0, cfg_min})
         prod = {16'd0, cfg_min};
      return prod[PERIOD_WIDTH-1:0];
   endfunction

   function automatic rsp_item_type advance_blinker(req_item_type it);
      rsp_item_type r;
      logic         toggled;
      toggled = 1'b0;
      case (it.kind)
         REQ_TICK: begin
            // blink reload sees the period from before any repeat step of this tick
            if (toggle_cnt <= 1) begin
               led_q      = ~led_q;
               toggled    = 1'b1;
               toggle_cnt = cur_period >> 1;
            end else begin
               toggle_cnt = toggle_cnt - 1'b1;
            end
            if (up_rpt_on) begin
               if (up_rpt_cnt > 1) begin
                  up_rpt_cnt = up_rpt_cnt - 1'b1;
               end else if (it.up_held) begin
                  up_rpt_cnt = cfg_repeat;
                  cur_period = scale_period_up(cur_period);
               end else begin
                  up_rpt_on = 1'b0;
               end
            end
            if (dn_rpt_on) begin
               if (dn_rpt_cnt > 1) begin
                  dn_rpt_cnt = dn_rpt_cnt - 1'b1;
               end else if (it.down_held) begin
                  dn_rpt_cnt = cfg_repeat;
                  cur_period = scale_period_down(cur_period);
               end else begin
                  dn_rpt_on = 1'b0;
               end
            end
         end
         REQ_UP: begin
            up_rpt_cnt = cfg_repeat;
            up_rpt_on  = 1'b1;
            cur_period = scale_period_up(cur_period);
         end
         REQ_RESET: begin
            cur_period = cfg_start;
         end
         REQ_DOWN: begin
            dn_rpt_cnt = cfg_repeat;
            dn_rpt_on  = 1'b1;
            cur_period = scale_period_down(cur_period);
         end
      endcase
      r.led_on         = led_q;
      r.led_changed    = toggled;
      r.current_period = cur_period;
      return r;
   endfunction

   function automatic void csr_row(csr_index_type idx, logic [PERIOD_WIDTH-1:0] value);
      stim_row_type r;
      r        = '0;
      r.is_csr = 1'b1;
      r.idx    = idx;
      r.value  = value;
      directed_rows.push_back(r);
   endfunction

   // LED stays off in typed rows: the blink countdown has not run out yet
   function automatic void req_row(req_kind_type kind, logic up, logic down, logic typed,
                                   logic [PERIOD_WIDTH-1:0] period);
      stim_row_type r;
      r        = '0;
      r.kind   = kind;
      r.up     = up;
      r.down   = down;
      r.typed  = typed;
      r.period = period;
      directed_rows.push_back(r);
   endfunction

   task automatic send_req(req_item_type it, int gap, bit typed, rsp_item_type typed_rsp);
      rsp_item_type pred;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {{(REQ_DATA_WIDTH-2){1'b0}}, it.down_held, it.up_held};
      do @(posedge clock); while (!req_tready);
      pred = advance_blinker(it);
      led_period_q.push_back(typed ? typed_rsp : pred);
   endtask

   task automatic drain_all();
      req_tvalid <= 1'b0;
      while (led_period_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [PERIOD_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_START_PERIOD:    cfg_start  = value;
         CSR_REPEAT_INTERVAL: cfg_repeat = value;
         CSR_MIN_PERIOD:      cfg_min    = value;
         CSR_MAX_PERIOD:      cfg_max    = value;
      endcase
      @(posedge clock);
   endtask

   initial begin : stimulus
      req_item_type            it;
      rsp_item_type            typed_rsp;
      stim_row_type            row;
      int                      pick;
      int                      gap;
      bit                      up_level;
      bit                      down_level;
      logic [PERIOD_WIDTH-1:0] v_start, v_repeat, v_min, v_max;

      cfg_start  = START_PERIOD_RESET;
      cfg_repeat = REPEAT_INTERVAL_RESET;
      cfg_min    = MIN_PERIOD_RESET;
      cfg_max    = MAX_PERIOD_RESET;
      cur_period = START_PERIOD_RESET;
      toggle_cnt = START_PERIOD_RESET >> 1;
      led_q      = 1'b0;
      up_rpt_cnt = '0;
      up_rpt_on  = 1'b0;
      dn_rpt_cnt = '0;
      dn_rpt_on  = 1'b0;
      up_level   = 1'b0;
      down_level = 1'b0;

      req_row(REQ_TICK,  1'b0, 1'b0, 1'b1, 16'd500);
      req_row(REQ_UP,    1'b1, 1'b0, 1'b1, 16'd600);
      req_row(REQ_TICK,  1'b1, 1'b0, 1'b0, 16'd0);
      req_row(REQ_DOWN,  1'b0, 1'b1, 1'b1, 16'd479);
      req_row(REQ_TICK,  1'b0, 1'b1, 1'b0, 16'd0);
      req_row(REQ_RESET, 1'b1, 1'b1, 1'b1, 16'd500);
      req_row(REQ_TICK,  1'b1, 1'b1, 1'b0, 16'd0);
      csr_row(CSR_START_PERIOD, 16'hFFFF);
      csr_row(CSR_MAX_PERIOD, 16'hFFFF);
      req_row(REQ_RESET, 1'b0, 1'b0, 1'b1, 16'hFFFF);
      req_row(REQ_UP,    1'b0, 1'b0, 1'b1, 16'hFFFF);   // saturates at the ceiling
      csr_row(CSR_MAX_PERIOD, 16'd100);
      req_row(REQ_UP,    1'b0, 1'b0, 1'b1, 16'd100);    // ceiling below current period
      csr_row(CSR_MIN_PERIOD, 16'd1000);
      req_row(REQ_DOWN,  1'b0, 1'b0, 1'b1, 16'd1000);   // floor above current period
      csr_row(CSR_MIN_PERIOD, 16'd0);
      csr_row(CSR_START_PERIOD, 16'd0);
      req_row(REQ_RESET, 1'b0, 1'b0, 1'b1, 16'd0);
      req_row(REQ_DOWN,  1'b0, 1'b0, 1'b1, 16'd0);
      req_row(REQ_UP,    1'b0, 1'b0, 1'b1, 16'd0);
      csr_row(CSR_START_PERIOD, 16'd1);
      req_row(REQ_RESET, 1'b0, 1'b0, 1'b1, 16'd1);
      req_row(REQ_UP,    1'b0, 1'b0, 1'b1, 16'd1);
      req_row(REQ_DOWN,  1'b0, 1'b0, 1'b1, 16'd0);
      csr_row(CSR_START_PERIOD, 16'd40);
      csr_row(CSR_REPEAT_INTERVAL, 16'd0);
      req_row(REQ_RESET, 1'b0, 1'b0, 1'b1, 16'd40);
      req_row(REQ_UP,    1'b1, 1'b0, 1'b1, 16'd48);
      // repeat while held, then stop once released
      req_row(REQ_TICK,  1'b1, 1'b0, 1'b0, 16'd0);
      req_row(REQ_TICK,  1'b0, 1'b0, 1'b0, 16'd0);
      req_row(REQ_DOWN,  1'b0, 1'b1, 1'b0, 16'd0);
      req_row(REQ_TICK,  1'b0, 1'b1, 1'b0, 16'd0);
      req_row(REQ_TICK,  1'b0, 1'b0, 1'b0, 16'd0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_csr) begin
            drain_all();
            write_csr(row.idx, row.value);
         end else begin
            it.kind                  = row.kind;
            it.up_held               = row.up;
            it.down_held             = row.down;
            typed_rsp.led_on         = 1'b0;
            typed_rsp.led_changed    = 1'b0;
            typed_rsp.current_period = row.period;
            send_req(it, $urandom_range(0, 5), row.typed, typed_rsp);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain_all();
         case (ph)
            5: begin
               v_start = '0; v_repeat = '0; v_min = '0; v_max = '0;
            end
            6: begin
               v_start  = START_PERIOD_RESET;
               v_repeat = REPEAT_INTERVAL_RESET;
               v_min    = MIN_PERIOD_RESET;
               v_max    = MAX_PERIOD_RESET;
            end
            7: begin
               v_start = '1; v_repeat = '1; v_min = '1; v_max = '1;
            end
            default: begin
               v_start  = PERIOD_WIDTH'($urandom_range(0, 100));
               v_repeat = PERIOD_WIDTH'($urandom_range(0, 15));
               v_min    = PERIOD_WIDTH'($urandom_range(0, 20));
               v_max    = PERIOD_WIDTH'($urandom_range(2, 300));
            end
         endcase
         write_csr(CSR_START_PERIOD, v_start);
         write_csr(CSR_REPEAT_INTERVAL, v_repeat);
         write_csr(CSR_MIN_PERIOD, v_min);
         write_csr(CSR_MAX_PERIOD, v_max);

         // back-to-back requests against a long response stall fill the unit
         send_idle_on = (ph != 2);
         if (ph == 2)
            hold_rsp_req = 1'b1;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph != 2 && n % 40 == 39)
               send_idle_on = 1'($urandom_range(0, 1));
            pick         = $urandom_range(0, 99);
            it.kind      = REQ_TICK;
            it.up_held   = up_level;
            it.down_held = down_level;
            if (pick < 8) begin
               // press sends an edge, release shows up as a tick with the level low
               up_level   = ~up_level;
               it.up_held = up_level;
               if (up_level)
                  it.kind = REQ_UP;
            end else if (pick < 16) begin
               down_level   = ~down_level;
               it.down_held = down_level;
               if (down_level)
                  it.kind = REQ_DOWN;
            end else if (pick < 19) begin
               it.kind = REQ_RESET;
            end else if (pick < 25) begin
               it.kind      = req_kind_type'($urandom_range(0, 3));
               it.up_held   = 1'($urandom_range(0, 1));
               it.down_held = 1'($urandom_range(0, 1));
            end
            gap = send_idle_on ? $urandom_range(0, 5) : 0;
            send_req(it, gap, 1'b0, typed_rsp);
         end
      end

      drain_all();
      if (mismatch_count == 0)
         $display("button_adjusted_led_blinker_unit_tb: PASS");
      else
         $display("button_adjusted_led_blinker_unit_tb: FAIL");
      $finish;
   end

   initial begin : rsp_sink
      int stall_left;
      int taken;
      stall_left = 0;
      taken      = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            stall_left   = LONG_HOLD;
         end else if (rsp_tvalid && rsp_tready) begin
            taken++;
            if (taken % 50 == 0)
               rsp_idle_on = 1'($urandom_range(0, 1));
            stall_left = rsp_idle_on ? $urandom_range(0, 5) : 0;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_tready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (led_period_q.size() == 0) begin
            $error("response with no request pending: rsp_tdata=%h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = led_period_q.pop_front();
            if (rsp_tdata[0] !== want.led_on) begin
               $error("led_on: expected %0d, actual %0d", want.led_on, rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[1] !== want.led_changed) begin
               $error("led_changed: expected %0d, actual %0d", want.led_changed, rsp_tdata[1]);
               mismatch_count++;
            end
            if (rsp_tdata[17:2] !== want.current_period) begin
               $error("current_period: expected %0d, actual %0d",
                      want.current_period, rsp_tdata[17:2]);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : watchdog
      #20_000_000;
      $display("button_adjusted_led_blinker_unit_tb: FAIL");
      $finish;
   end

endmodule

// File: button_adjusted_led_blinker_unit.f
design/baled_pkg.sv
design/baled_step.sv
design/button_adjusted_led_blinker_unit.sv
sim/button_adjusted_led_blinker_unit_tb.sv
